@@ sv/shuffled_minimal_standard_prng_macros.svh @@
// Assertion macros for the shuffled minimal standard generator.
// Included by the checker; needs no other file.
`ifndef SHUFFLED_MINIMAL_STANDARD_PRNG_MACROS_SVH
`define SHUFFLED_MINIMAL_STANDARD_PRNG_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SMSP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("smsp assertion failed");

// Antecedent in any cycle implies consequent in the next.
`define SMSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smsp assertion failed");

`endif

@@ sv/smsp_pkg.sv @@
// Package for the shuffled minimal standard generator: constants, types and
// the generator step / slot select functions. No dependencies.
`timescale 1ns / 1ps

package smsp_pkg;

	localparam int TABLE_DEPTH  = 32;
	localparam int IDX_W        = $clog2(TABLE_DEPTH);
	localparam int VAL_W        = 31;
	localparam int MULT_W       = 15;
	localparam int WARMUP_STEPS = TABLE_DEPTH + 8;
	localparam int WCNT_W       = $clog2(WARMUP_STEPS);

	localparam logic [VAL_W-1:0]  MODULUS    = 31'h7FFF_FFFF;
	localparam logic [MULT_W-1:0] MULTIPLIER = 15'd16807;
	localparam logic [VAL_W-1:0]  SLOT_DIV   = VAL_W'(1 + (2147483646 / TABLE_DEPTH));

	typedef logic [VAL_W-1:0] value_t;
	typedef logic [IDX_W-1:0] slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WARM,
		ST_READ,
		ST_WB
	} state_t;

	// x * 16807 mod (2^31 - 1), folding the high bits back in (Mersenne modulus)
	function automatic value_t next_value(value_t x);
		logic [VAL_W+MULT_W-1:0] p;
		logic [VAL_W:0]          s;
		p = {{MULT_W{1'b0}}, x} * {{VAL_W{1'b0}}, MULTIPLIER};
		s = {1'b0, p[VAL_W-1:0]} + {{(VAL_W+1-MULT_W){1'b0}}, p[VAL_W+MULT_W-1:VAL_W]};
		if (s >= {1'b0, MODULUS})
			s = s - {1'b0, MODULUS};
		return s[VAL_W-1:0];
	endfunction

	// seed reduced mod 2^31-1, zero mapped to one
	function automatic value_t fix_seed(value_t s);
		return ((s == '0) || (s == MODULUS)) ? VAL_W'(1) : s;
	endfunction

	// x / SLOT_DIV by thermometer compare against constant thresholds
	function automatic slot_t slot_of(value_t x);
		logic [TABLE_DEPTH:0] ge;
		slot_t                idx;
		ge              = '0;
		ge[0]           = 1'b1;
		for (int k = 1; k < TABLE_DEPTH; k++)
			ge[k] = (64'(x) >= (64'(k) * 64'(SLOT_DIV)));
		idx = '0;
		for (int k = 0; k < TABLE_DEPTH; k++)
			if (ge[k] && !ge[k+1])
				idx = idx | IDX_W'(k);
		return idx;
	endfunction

endpackage

@@ sv/smsp_in_if.sv @@
// Request channel of the shuffled minimal standard generator.
// Depends on smsp_pkg.
`timescale 1ns / 1ps

interface smsp_in_if;
	import smsp_pkg::*;

	logic   valid;
	logic   ready;
	logic   action;
	value_t seed_value;

	modport source (output valid, output action, output seed_value, input ready);
	modport sink (input valid, input action, input seed_value, output ready);
	modport monitor (input valid, input ready, input action, input seed_value);
endinterface

@@ sv/smsp_out_if.sv @@
// Result channel of the shuffled minimal standard generator.
// Depends on smsp_pkg.
`timescale 1ns / 1ps

interface smsp_out_if;
	import smsp_pkg::*;

	logic   valid;
	logic   ready;
	value_t random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
	modport monitor (input valid, input ready, input random_value);
endinterface

@@ sv/smsp_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module smsp_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ sv/shuffled_minimal_standard_prng.sv @@
// Shuffled minimal standard generator, top level.
// Depends on smsp_pkg, smsp_in_if, smsp_out_if and smsp_ram.
//
// Park-Miller generator (x = 16807 * x mod 2^31-1) behind a Bays-Durham
// shuffle table held in one synchronous RAM. A reseed request (action 1)
// loads the seed and arms a table fill. A draw request (action 0) first
// reads the slot picked by the previous result and steps the generator in
// its accept cycle; then, in the write-back state, it returns the slot and
// writes the new generator value back into it. The first draw after reset or
// a reseed first runs TABLE_DEPTH + 8 = 40 generator steps, one per cycle,
// filling the table. Results sit in an output register; a draw whose
// result cannot be handed over waits in its write-back state.
`timescale 1ns / 1ps

module shuffled_minimal_standard_prng (
	input  logic    clk,
	input  logic    arst_n,
	smsp_in_if.sink   request,
	smsp_out_if.source result
);
	import smsp_pkg::*;

	state_t              state_q, state_d;
	value_t              gen_q;
	value_t              prev_q;
	logic                pend_q;
	logic [WCNT_W-1:0]   wcnt_q;
	slot_t               slot_s1;
	logic                out_vld_q;
	value_t              out_val_q;

	value_t step_val;
	slot_t  cur_slot;
	logic   out_free;
	logic   req_fire;

	logic   ram_we;
	slot_t  ram_waddr;
	value_t ram_wdata;
	logic   ram_re;
	value_t ram_rdata;

	assign step_val = next_value(gen_q);
	assign cur_slot = slot_of(prev_q);
	assign out_free = !out_vld_q || result.ready;
	assign req_fire = request.valid && request.ready;

	assign result.valid        = out_vld_q;
	assign result.random_value = out_val_q;

	smsp_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cur_slot),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d       = state_q;
		request.ready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = slot_s1;
		ram_wdata     = gen_q;
		ram_re        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				request.ready = 1'b1;
				if (request.valid && !request.action) begin
					if (pend_q) begin
						state_d = ST_WARM;
					end else begin
						ram_re  = 1'b1;
						state_d = ST_WB;
					end
				end
			end
			ST_WARM: begin
				// last TABLE_DEPTH steps land in slots high to low
				if (wcnt_q < WCNT_W'(TABLE_DEPTH)) begin
					ram_we    = 1'b1;
					ram_waddr = wcnt_q[IDX_W-1:0];
					ram_wdata = step_val;
				end
				if (wcnt_q == '0)
					state_d = ST_READ;
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				if (out_free) begin
					ram_we  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			gen_q     <= VAL_W'(1);
			prev_q    <= '0;
			pend_q    <= 1'b1;
			wcnt_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WB && out_free)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (request.action) begin
							gen_q  <= fix_seed(request.seed_value);
							pend_q <= 1'b1;
						end else if (pend_q) begin
							wcnt_q <= WCNT_W'(WARMUP_STEPS - 1);
						end else begin
							gen_q <= step_val;
						end
					end
				end
				ST_WARM: begin
					gen_q  <= step_val;
					wcnt_q <= wcnt_q - WCNT_W'(1);
					// slot 0 is the last fill and seeds the slot select
					if (wcnt_q == '0) begin
						prev_q <= step_val;
						pend_q <= 1'b0;
					end
				end
				ST_READ: begin
					gen_q <= step_val;
				end
				ST_WB: begin
					if (out_free)
						prev_q <= ram_rdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re)
			slot_s1 <= cur_slot;
		if (state_q == ST_WB && out_free)
			out_val_q <= ram_rdata;
	end

endmodule

@@ sv/smsp_checker.sv @@
// Port-level checker for the shuffled minimal standard generator, bound to
// the top level. Depends on smsp_pkg and the macro header.
`timescale 1ns / 1ps
`include "shuffled_minimal_standard_prng_macros.svh"

module smsp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              req_action,
	input logic              res_valid,
	input logic              res_ready,
	input smsp_pkg::value_t  res_value
);

	`SMSP_ASSERT_NEXT(a_out_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`SMSP_ASSERT_NEXT(a_out_stable, clk, arst_n, res_valid && !res_ready, $stable(res_value))
	// a draw keeps the block busy for at least the following cycle
	`SMSP_ASSERT_NEXT(a_draw_busy, clk, arst_n, req_valid && req_ready && !req_action, !req_ready)
	// shuffled values never hit zero or the modulus
	`SMSP_ASSERT(a_out_range, clk, arst_n, res_valid |-> (res_value != '0 && res_value != '1))

endmodule

bind shuffled_minimal_standard_prng smsp_checker u_smsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.req_action(request.action),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_value (result.random_value)
);
